// ===== hw/rtl/adaptive_rood_block_motion_search_defines.svh =====
// Assertion macros shared by the checker of the motion search block.
`ifndef ADAPTIVE_ROOD_BLOCK_MOTION_SEARCH_DEFINES_SVH
`define ADAPTIVE_ROOD_BLOCK_MOTION_SEARCH_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define ARBMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define ARBMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/arbms_pkg.sv =====
// Types and constants of the adaptive rood motion search block.
package arbms_pkg;

  localparam int FUNC_W   = 2;
  localparam int ROW_W    = 9;
  localparam int COL_W    = 10;
  localparam int PIX_W    = 8;
  localparam int MVX_W    = 11;
  localparam int MVY_W    = 10;
  localparam int SADO_W   = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int FW_W  = 11;
  localparam int FH_W  = 10;
  localparam int SR_W  = 3;
  localparam int THR_W = 8;

  localparam logic [FW_W-1:0]  FW_RST  = 11'd640;
  localparam logic [FH_W-1:0]  FH_RST  = 10'd480;
  localparam logic [SR_W-1:0]  SR_RST  = 3'd3;
  localparam logic [THR_W-1:0] THR_RST = 8'd8;

  localparam int COST_CEIL   = 256;
  localparam int DEFAULT_ARM = 3;
  localparam logic [3:0] CAND_SHORT = 4'd8;
  localparam logic [3:0] CAND_LONG  = 4'd9;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_ANCHOR = 2'd0,
    FUNC_LOAD_SEARCH = 2'd1,
    FUNC_SEARCH      = 2'd2,
    FUNC_NONE        = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_SEARCH_RANGE = 2'd2,
    CFG_THRESHOLD    = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SAD, S_EVAL, S_LEFT, S_CAND, S_SQ, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_ZERO, PH_CAND, PH_SQ
  } phase_t;

endpackage

// ===== hw/rtl/arbms_channels.sv =====
// Handshake channels of the motion search block: input words and result words.
interface arbms_in_if;
  logic                           valid;
  logic                           ready;
  logic [arbms_pkg::FUNC_W-1:0]   func;
  logic [arbms_pkg::ROW_W-1:0]    row;
  logic [arbms_pkg::COL_W-1:0]    col;
  logic [arbms_pkg::PIX_W-1:0]    pixel;
  modport source (output valid, func, row, col, pixel, input ready);
  modport sink   (input valid, func, row, col, pixel, output ready);
endinterface

interface arbms_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [arbms_pkg::MVX_W-1:0] mv_x;
  logic signed [arbms_pkg::MVY_W-1:0] mv_y;
  logic [arbms_pkg::SADO_W-1:0]       best_sad;
  modport source (output valid, mv_x, mv_y, best_sad, input ready);
  modport sink   (input valid, mv_x, mv_y, best_sad, output ready);
endinterface

// ===== hw/rtl/adaptive_rood_block_motion_search.sv =====
// Adaptive rood pattern block motion search: frame stores, SAD sequencer and result register.
//
// The block keeps an anchor frame and a search frame of grey pixels, loaded one pixel per
// input word, and returns one motion vector per search word. A search runs on a single
// SAD unit that reads one anchor pixel and one search pixel per cycle from the two frame
// memories. A search first tries zero motion, then up to nine rood points whose arm comes
// from the left block's stored vector (a default arm when that is zero or the block is in
// the first column), then a square of side 2*search_range+1 around the best point; it ends
// early once a SAD falls below threshold*BLOCK_SIZE^2. The worst case at the defaults is
// about 1+9+49 candidates, while a still block under the threshold needs only the
// zero-motion candidate. The input is not ready during a search. After reset a clearing
// pass writes zero into every stored block vector, one per cycle, for all
// (MAX_WIDTH/BLOCK_SIZE)*(MAX_HEIGHT/BLOCK_SIZE) of them (8192 at the defaults);
// configuration writes are taken during it. Results sit in an output register, so loads
// keep flowing while a result waits to be taken. Searches of blocks outside the active
// frame, loads outside the store and the unused function code give no result.
module adaptive_rood_block_motion_search #(
  parameter int BLOCK_SIZE = 8,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                                clk,
  input  logic                                rst_n,
  arbms_in_if.sink                            in_word,
  arbms_out_if.source                         out_word,
  input  logic                                cfg_we,
  input  logic [arbms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [arbms_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int NPIX  = BLOCK_SIZE * BLOCK_SIZE;
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int BPR   = MAX_WIDTH / BLOCK_SIZE;
  localparam int NBLK  = BPR * (MAX_HEIGHT / BLOCK_SIZE);
  localparam int BW    = $clog2(NBLK);
  localparam int CEIL  = arbms_pkg::COST_CEIL * NPIX;
  localparam int SW    = $clog2(CEIL + 1);
  localparam int MXD   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CW    = $clog2(MXD) + 3;
  localparam int PW    = $clog2(BLOCK_SIZE + 1);
  localparam int OW    = 5;

  localparam logic signed [CW-1:0] BSC = CW'(BLOCK_SIZE);

  // Frame memories and the stored block vectors.
  logic [arbms_pkg::PIX_W-1:0] anchor_mem [CELLS];
  logic [arbms_pkg::PIX_W-1:0] search_mem [CELLS];
  logic [2*CW-1:0]             vec_mem    [NBLK];

  arbms_pkg::state_t state_r, state_nxt;
  arbms_pkg::phase_t phase_r, phase_nxt;

  logic [arbms_pkg::FW_W-1:0]  frame_width_r;
  logic [arbms_pkg::FH_W-1:0]  frame_height_r;
  logic [arbms_pkg::SR_W-1:0]  search_range_r;
  logic [arbms_pkg::THR_W-1:0] threshold_r;

  logic [CW-1:0]          i_r, i_nxt, j_r, j_nxt;
  logic [BW-1:0]          idx_r, idx_nxt, clr_r, clr_nxt;
  logic                   col0_r, col0_nxt;
  logic signed [CW-1:0]   cy_r, cy_nxt, cx_r, cx_nxt;
  logic [PW-1:0]          pr_r, pr_nxt, pc_r, pc_nxt;
  logic                   rdv_r, rdv_nxt;
  logic [SW-1:0]          sum_r, sum_nxt, best_r, best_nxt;
  logic signed [CW-1:0]   mvx_r, mvx_nxt, mvy_r, mvy_nxt;
  logic signed [CW-1:0]   lx_r, lx_nxt, ly_r, ly_nxt;
  logic signed [CW-1:0]   t_r, t_nxt;
  logic                   n9_r, n9_nxt;
  logic [3:0]             ci_r, ci_nxt;
  logic signed [CW-1:0]   cenx_r, cenx_nxt, ceny_r, ceny_nxt;
  logic signed [OW-1:0]   ox_r, ox_nxt, oy_r, oy_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic signed [arbms_pkg::MVX_W-1:0] out_mvx_r, out_mvx_nxt;
  logic signed [arbms_pkg::MVY_W-1:0] out_mvy_r, out_mvy_nxt;
  logic [arbms_pkg::SADO_W-1:0]       out_sad_r, out_sad_nxt;

  logic [arbms_pkg::PIX_W-1:0] a_rd_r, s_rd_r;
  logic [2*CW-1:0]             left_rd_r;

  logic              anc_we, srch_we;
  logic [AW-1:0]     ld_addr, a_raddr, s_raddr;
  logic              vec_we;
  logic [BW-1:0]     vec_waddr, left_addr;
  logic [2*CW-1:0]   vec_wdata;

  logic [31:0]       ld_full, blk_i, blk_j, w_eff, h_eff, a_full, s_full;
  logic              ld_in_store, blk_fits, in_ready, accept;
  logic signed [CW-1:0] w_s, h_s;
  logic [SW-1:0]     thr;
  logic [arbms_pkg::PIX_W-1:0] adiff;
  logic signed [CW-1:0] dx, dy, ax, ay, tcy, tcx, lxv, lyv;
  logic signed [OW-1:0] p_s;

  function automatic logic fits_f(input logic signed [CW-1:0] y, x, w, h, bs);
    fits_f = !y[CW-1] && !x[CW-1] && (x + bs <= w) && (y + bs <= h);
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= arbms_pkg::FW_RST;
      frame_height_r <= arbms_pkg::FH_RST;
      search_range_r <= arbms_pkg::SR_RST;
      threshold_r    <= arbms_pkg::THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        arbms_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[arbms_pkg::FW_W-1:0];
        arbms_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[arbms_pkg::FH_W-1:0];
        arbms_pkg::CFG_SEARCH_RANGE: search_range_r <= cfg_data[arbms_pkg::SR_W-1:0];
        arbms_pkg::CFG_THRESHOLD:    threshold_r    <= cfg_data[arbms_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size, clamped to the store.
  assign w_eff = (32'(frame_width_r) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(frame_width_r);
  assign h_eff = (32'(frame_height_r) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT)
                                                         : 32'(frame_height_r);
  assign w_s   = CW'(w_eff);
  assign h_s   = CW'(h_eff);
  assign thr   = SW'(threshold_r) * SW'(NPIX);
  assign p_s   = OW'(search_range_r);

  assign in_ready      = (state_r == arbms_pkg::S_IDLE);
  assign in_word.ready = in_ready;
  assign accept        = in_word.valid && in_ready;

  // Load address and search block position.
  assign ld_full     = 32'(in_word.row) * 32'(MAX_WIDTH) + 32'(in_word.col);
  assign ld_addr     = AW'(ld_full);
  assign ld_in_store = (32'(in_word.row) < 32'(MAX_HEIGHT)) && (32'(in_word.col) < 32'(MAX_WIDTH));
  assign blk_i       = 32'(in_word.row) * 32'(BLOCK_SIZE);
  assign blk_j       = 32'(in_word.col) * 32'(BLOCK_SIZE);
  assign blk_fits    = (blk_j + 32'(BLOCK_SIZE) <= w_eff) && (blk_i + 32'(BLOCK_SIZE) <= h_eff);

  assign anc_we  = accept && (in_word.func == arbms_pkg::FUNC_LOAD_ANCHOR) && ld_in_store;
  assign srch_we = accept && (in_word.func == arbms_pkg::FUNC_LOAD_SEARCH) && ld_in_store;

  // Pixel read addresses of the SAD unit.
  assign a_full  = 32'(i_r + CW'(pr_r)) * 32'(MAX_WIDTH) + 32'(j_r + CW'(pc_r));
  assign s_full  = 32'($unsigned(cy_r + CW'(pr_r))) * 32'(MAX_WIDTH)
                 + 32'($unsigned(cx_r + CW'(pc_r)));
  assign a_raddr = AW'(a_full);
  assign s_raddr = AW'(s_full);
  assign adiff   = (a_rd_r > s_rd_r) ? (a_rd_r - s_rd_r) : (s_rd_r - a_rd_r);

  assign left_addr = idx_r - BW'(1);

  always_ff @(posedge clk) begin
    if (anc_we) anchor_mem[ld_addr] <= in_word.pixel;
    a_rd_r <= anchor_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (srch_we) search_mem[ld_addr] <= in_word.pixel;
    s_rd_r <= search_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (vec_we) vec_mem[vec_waddr] <= vec_wdata;
    left_rd_r <= vec_mem[left_addr];
  end

  // Left vector and rood arm.
  assign lxv = col0_r ? '0 : $signed(left_rd_r[CW-1:0]);
  assign lyv = col0_r ? '0 : $signed(left_rd_r[2*CW-1:CW]);
  assign ax  = lxv[CW-1] ? -lxv : lxv;
  assign ay  = lyv[CW-1] ? -lyv : lyv;

  always_comb begin
    dx = '0;
    dy = '0;
    case (ci_r)
      4'd0: begin dx = -t_r; dy = '0;   end
      4'd1: begin dx = t_r;  dy = '0;   end
      4'd2: begin dx = '0;   dy = -t_r; end
      4'd3: begin dx = '0;   dy = t_r;  end
      4'd4: begin dx = -t_r; dy = -t_r; end
      4'd5: begin dx = t_r;  dy = -t_r; end
      4'd6: begin dx = -t_r; dy = t_r;  end
      4'd7: begin dx = t_r;  dy = t_r;  end
      default: begin dx = lx_r; dy = ly_r; end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    idx_nxt       = idx_r;
    clr_nxt       = clr_r;
    col0_nxt      = col0_r;
    cy_nxt        = cy_r;
    cx_nxt        = cx_r;
    pr_nxt        = pr_r;
    pc_nxt        = pc_r;
    rdv_nxt       = 1'b0;
    sum_nxt       = sum_r;
    best_nxt      = best_r;
    mvx_nxt       = mvx_r;
    mvy_nxt       = mvy_r;
    lx_nxt        = lx_r;
    ly_nxt        = ly_r;
    t_nxt         = t_r;
    n9_nxt        = n9_r;
    ci_nxt        = ci_r;
    cenx_nxt      = cenx_r;
    ceny_nxt      = ceny_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    out_valid_nxt = out_valid_r && !out_word.ready;
    out_mvx_nxt   = out_mvx_r;
    out_mvy_nxt   = out_mvy_r;
    out_sad_nxt   = out_sad_r;
    vec_we        = 1'b0;
    vec_waddr     = idx_r;
    vec_wdata     = {mvy_r, mvx_r};
    tcy           = '0;
    tcx           = '0;

    case (state_r)
      arbms_pkg::S_CLR: begin
        vec_we    = 1'b1;
        vec_waddr = clr_r;
        vec_wdata = '0;
        clr_nxt   = clr_r + BW'(1);
        if (32'(clr_r) == NBLK - 1) state_nxt = arbms_pkg::S_IDLE;
      end

      arbms_pkg::S_IDLE: begin
        if (accept && (in_word.func == arbms_pkg::FUNC_SEARCH) && blk_fits) begin
          i_nxt     = CW'(blk_i);
          j_nxt     = CW'(blk_j);
          idx_nxt   = BW'(32'(in_word.row) * 32'(BPR) + 32'(in_word.col));
          col0_nxt  = (in_word.col == '0);
          cy_nxt    = CW'(blk_i);
          cx_nxt    = CW'(blk_j);
          mvx_nxt   = '0;
          mvy_nxt   = '0;
          phase_nxt = arbms_pkg::PH_ZERO;
          pr_nxt    = '0;
          pc_nxt    = '0;
          sum_nxt   = '0;
          state_nxt = arbms_pkg::S_SAD;
        end
      end

      arbms_pkg::S_SAD: begin
        if (32'(pr_r) != BLOCK_SIZE) begin
          rdv_nxt = 1'b1;
          if (32'(pc_r) == BLOCK_SIZE - 1) begin
            pc_nxt = '0;
            pr_nxt = pr_r + PW'(1);
          end else begin
            pc_nxt = pc_r + PW'(1);
          end
        end else if (!rdv_r) begin
          state_nxt = arbms_pkg::S_EVAL;
        end
        if (rdv_r) sum_nxt = sum_r + SW'(adiff);
      end

      arbms_pkg::S_EVAL: begin
        case (phase_r)
          arbms_pkg::PH_ZERO: begin
            if (sum_r < thr) begin
              best_nxt  = sum_r;
              state_nxt = arbms_pkg::S_FIN;
            end else begin
              best_nxt  = SW'(CEIL);
              state_nxt = arbms_pkg::S_LEFT;
            end
          end
          default: begin
            state_nxt = (phase_r == arbms_pkg::PH_SQ) ? arbms_pkg::S_SQ : arbms_pkg::S_CAND;
            if (sum_r < best_r) begin
              best_nxt = sum_r;
              mvx_nxt  = cx_r - $signed(j_r);
              mvy_nxt  = cy_r - $signed(i_r);
              if (sum_r < thr) state_nxt = arbms_pkg::S_FIN;
            end
          end
        endcase
      end

      arbms_pkg::S_LEFT: begin
        lx_nxt = lxv;
        ly_nxt = lyv;
        ci_nxt = '0;
        if (lxv == '0 && lyv == '0) begin
          t_nxt  = CW'(arbms_pkg::DEFAULT_ARM);
          n9_nxt = 1'b0;
        end else begin
          t_nxt  = (ax > ay) ? ax : ay;
          n9_nxt = 1'b1;
        end
        state_nxt = arbms_pkg::S_CAND;
      end

      arbms_pkg::S_CAND: begin
        if (ci_r == (n9_r ? arbms_pkg::CAND_LONG : arbms_pkg::CAND_SHORT)) begin
          cenx_nxt  = mvx_r;
          ceny_nxt  = mvy_r;
          ox_nxt    = -p_s;
          oy_nxt    = -p_s;
          state_nxt = arbms_pkg::S_SQ;
        end else begin
          tcy    = $signed(i_r) + dy;
          tcx    = $signed(j_r) + dx;
          ci_nxt = ci_r + 4'd1;
          if (fits_f(tcy, tcx, w_s, h_s, BSC)) begin
            cy_nxt    = tcy;
            cx_nxt    = tcx;
            phase_nxt = arbms_pkg::PH_CAND;
            pr_nxt    = '0;
            pc_nxt    = '0;
            sum_nxt   = '0;
            state_nxt = arbms_pkg::S_SAD;
          end
        end
      end

      arbms_pkg::S_SQ: begin
        if (oy_r > p_s) begin
          state_nxt = arbms_pkg::S_FIN;
        end else begin
          tcy = $signed(i_r) + ceny_r + CW'(oy_r);
          tcx = $signed(j_r) + cenx_r + CW'(ox_r);
          if (ox_r == p_s) begin
            ox_nxt = -p_s;
            oy_nxt = oy_r + OW'(1);
          end else begin
            ox_nxt = ox_r + OW'(1);
          end
          if (fits_f(tcy, tcx, w_s, h_s, BSC)) begin
            cy_nxt    = tcy;
            cx_nxt    = tcx;
            phase_nxt = arbms_pkg::PH_SQ;
            pr_nxt    = '0;
            pc_nxt    = '0;
            sum_nxt   = '0;
            state_nxt = arbms_pkg::S_SAD;
          end
        end
      end

      arbms_pkg::S_FIN: begin
        vec_we = 1'b1;
        if (!out_valid_r || out_word.ready) begin
          out_valid_nxt = 1'b1;
          out_mvx_nxt   = arbms_pkg::MVX_W'(mvx_r);
          out_mvy_nxt   = arbms_pkg::MVY_W'(mvy_r);
          out_sad_nxt   = arbms_pkg::SADO_W'(best_r);
          state_nxt     = arbms_pkg::S_IDLE;
        end
      end

      default: state_nxt = arbms_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arbms_pkg::S_CLR;
      clr_r       <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r   <= phase_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    idx_r     <= idx_nxt;
    col0_r    <= col0_nxt;
    cy_r      <= cy_nxt;
    cx_r      <= cx_nxt;
    pr_r      <= pr_nxt;
    pc_r      <= pc_nxt;
    sum_r     <= sum_nxt;
    best_r    <= best_nxt;
    mvx_r     <= mvx_nxt;
    mvy_r     <= mvy_nxt;
    lx_r      <= lx_nxt;
    ly_r      <= ly_nxt;
    t_r       <= t_nxt;
    n9_r      <= n9_nxt;
    ci_r      <= ci_nxt;
    cenx_r    <= cenx_nxt;
    ceny_r    <= ceny_nxt;
    ox_r      <= ox_nxt;
    oy_r      <= oy_nxt;
    out_mvx_r <= out_mvx_nxt;
    out_mvy_r <= out_mvy_nxt;
    out_sad_r <= out_sad_nxt;
  end

  assign out_word.valid    = out_valid_r;
  assign out_word.mv_x     = out_mvx_r;
  assign out_word.mv_y     = out_mvy_r;
  assign out_word.best_sad = out_sad_r;

endmodule

// ===== hw/rtl/arbms_checker.sv =====
// Port-level checker of the motion search block and its bind.
`include "adaptive_rood_block_motion_search_defines.svh"

module arbms_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // A result word is never withdrawn before it is taken.
  `ARBMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")

  // A new result only follows a search, never an accepted word in the cycle before.
  `ARBMS_ASSERT_NEXT(a_no_early_result, in_valid && in_ready, !$rose(out_valid), "early result")

  // The vector clearing pass keeps the input closed right after reset.
  `ARBMS_ASSERT_IMP(a_closed_after_reset, $past(!rst_n), !in_ready && !out_valid, "open in reset")

endmodule

bind adaptive_rood_block_motion_search arbms_checker u_arbms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_word.valid),
  .in_ready  (in_word.ready),
  .out_valid (out_word.valid),
  .out_ready (out_word.ready)
);

// ===== sim/adaptive_rood_block_motion_search_tb.sv =====
// Self-checking testbench of the adaptive rood motion search block.
module adaptive_rood_block_motion_search_tb;

  localparam int BS = 8;
  localparam int MW = 1024;
  localparam int MH = 512;
  localparam int BLOCKS_PER_ROW = MW / BS;
  localparam int BLOCK_COUNT = BLOCKS_PER_ROW * (MH / BS);

  // One input word and one expected result word.
  typedef struct packed {
    arbms_pkg::func_t func;
    logic [8:0]       row;
    logic [9:0]       col;
    logic [7:0]       pixel;
  } pixel_word_t;

  typedef struct packed {
    logic signed [arbms_pkg::MVX_W-1:0] mv_x;
    logic signed [arbms_pkg::MVY_W-1:0] mv_y;
    logic [arbms_pkg::SADO_W-1:0]       best_sad;
  } motion_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [arbms_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [arbms_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  arbms_in_if  in_if();
  arbms_out_if out_if();

  adaptive_rood_block_motion_search #(
    .BLOCK_SIZE(BS), .MAX_WIDTH(MW), .MAX_HEIGHT(MH)
  ) i_dut (
    .clk(clk), .rst_n(rst_n), .in_word(in_if.sink), .out_word(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Words still to be sent and motion vectors still to come back.
  pixel_word_t pending_words[$];
  motion_t     expected_vectors[$];

  // Our own copy of the frame stores, the stored block vectors and the registers.
  logic [7:0] anchor_px [0:MW*MH-1];
  logic [7:0] search_px [0:MW*MH-1];
  int stored_mvx [0:BLOCK_COUNT-1];
  int stored_mvy [0:BLOCK_COUNT-1];
  int unsigned width_reg = 640;
  int unsigned height_reg = 480;
  int unsigned range_reg = 3;
  int unsigned thr_reg = 8;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  bit in_acc = 1'b0;

  function automatic bit block_fits(int y, int x, int w, int h);
    return x >= 0 && x + BS <= w && y >= 0 && y + BS <= h;
  endfunction

  function automatic int unsigned block_cost(int ay, int ax, int sy, int sx);
    int unsigned sum;
    int d;
    sum = 0;
    for (int r = 0; r < BS; r++) begin
      for (int c = 0; c < BS; c++) begin
        d = int'(anchor_px[((ay + r) * MW + ax + c) % (MW * MH)])
          - int'(search_px[((sy + r) * MW + sx + c) % (MW * MH)]);
        sum += (d < 0) ? -d : d;
      end
    end
    return sum;
  endfunction

  // Tries one candidate position; a strictly lower cost is taken, and a taken cost
  // under the threshold finishes the search.
  function automatic void try_candidate(int cy, int cx, int i, int j, int w, int h,
                                        int unsigned thr, inout bit done,
                                        inout int unsigned best, inout int mvx,
                                        inout int mvy);
    int unsigned cost;
    if (done || !block_fits(cy, cx, w, h)) return;
    cost = block_cost(i, j, cy, cx);
    if (cost < best) begin
      best = cost;
      mvx = cx - j;
      mvy = cy - i;
      if (best < thr) done = 1'b1;
    end
  endfunction

  // Applies one accepted word to our copy of the state and queues its result, if any.
  function automatic void predict_motion(pixel_word_t wd);
    int w, h, i, j, idx, lx, ly, arm, npts, mvx, mvy, p, ax, ay;
    int unsigned thr, best;
    bit done;
    int pdx [0:8];
    int pdy [0:8];
    motion_t res;
    w = (width_reg > MW) ? MW : width_reg;
    h = (height_reg > MH) ? MH : height_reg;
    if (wd.func == arbms_pkg::FUNC_LOAD_ANCHOR || wd.func == arbms_pkg::FUNC_LOAD_SEARCH) begin
      if (wd.row < MH && wd.col < MW) begin
        if (wd.func == arbms_pkg::FUNC_LOAD_ANCHOR) anchor_px[wd.row * MW + wd.col] = wd.pixel;
        else search_px[wd.row * MW + wd.col] = wd.pixel;
      end
      return;
    end
    if (wd.func != arbms_pkg::FUNC_SEARCH) return;
    i = wd.row * BS;
    j = wd.col * BS;
    if (!block_fits(i, j, w, h)) return;
    idx = wd.row * BLOCKS_PER_ROW + wd.col;
    thr = thr_reg * BS * BS;
    mvx = 0;
    mvy = 0;
    done = 1'b0;
    best = block_cost(i, j, i, j);
    if (best >= thr) begin
      best = arbms_pkg::COST_CEIL * BS * BS;
      lx = 0;
      ly = 0;
      if (wd.col != 0) begin
        lx = stored_mvx[idx - 1];
        ly = stored_mvy[idx - 1];
      end
      // The rood arm follows the left neighbor's vector unless there is none to use.
      if (wd.col == 0 || (lx == 0 && ly == 0)) begin
        arm = arbms_pkg::DEFAULT_ARM;
        npts = 8;
      end else begin
        ax = (lx < 0) ? -lx : lx;
        ay = (ly < 0) ? -ly : ly;
        arm = (ax > ay) ? ax : ay;
        npts = 9;
      end
      pdx = '{-arm, arm, 0, 0, -arm, arm, -arm, arm, lx};
      pdy = '{0, 0, -arm, arm, -arm, -arm, arm, arm, ly};
      for (int k = 0; k < npts; k++)
        try_candidate(i + pdy[k], j + pdx[k], i, j, w, h, thr, done, best, mvx, mvy);
      p = range_reg;
      lx = mvx;
      ly = mvy;
      for (int y = i + ly - p; y <= i + ly + p; y++)
        for (int x = j + lx - p; x <= j + lx + p; x++)
          try_candidate(y, x, i, j, w, h, thr, done, best, mvx, mvy);
    end
    stored_mvx[idx] = mvx;
    stored_mvy[idx] = mvy;
    res.mv_x = arbms_pkg::MVX_W'(mvx);
    res.mv_y = arbms_pkg::MVY_W'(mvy);
    res.best_sad = arbms_pkg::SADO_W'(best);
    expected_vectors.push_back(res);
  endfunction

  // Input driver: a word stays on the bus until it is taken, then the next one may
  // follow at once or after a random idle gap.
  always @(negedge clk) begin
    pixel_word_t wd;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.func  <= '0;
      in_if.row   <= '0;
      in_if.col   <= '0;
      in_if.pixel <= '0;
    end else if (!in_if.valid || in_acc) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        wd = pending_words.pop_front();
        in_if.func  <= wd.func;
        in_if.row   <= wd.row;
        in_if.col   <= wd.col;
        in_if.pixel <= wd.pixel;
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    out_if.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Input monitor: every accepted word goes through the predictor.
  always @(posedge clk) begin
    pixel_word_t wd;
    in_acc = rst_n && in_if.valid && in_if.ready;
    if (in_acc) begin
      wd.func = arbms_pkg::func_t'(in_if.func);
      wd.row = in_if.row;
      wd.col = in_if.col;
      wd.pixel = in_if.pixel;
      predict_motion(wd);
    end
  end

  // Result monitor: each taken result word is checked against the oldest expectation.
  always @(posedge clk) begin
    motion_t exp_mv;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_vectors.size() == 0) begin
        $error("unexpected result word: mv_x %0d mv_y %0d best_sad %0d",
               out_if.mv_x, out_if.mv_y, out_if.best_sad);
        errors++;
      end else begin
        exp_mv = expected_vectors.pop_front();
        if (out_if.mv_x !== exp_mv.mv_x) begin
          $error("mv_x expected %0d actual %0d", exp_mv.mv_x, out_if.mv_x);
          errors++;
        end
        if (out_if.mv_y !== exp_mv.mv_y) begin
          $error("mv_y expected %0d actual %0d", exp_mv.mv_y, out_if.mv_y);
          errors++;
        end
        if (out_if.best_sad !== exp_mv.best_sad) begin
          $error("best_sad expected %0d actual %0d", exp_mv.best_sad, out_if.best_sad);
          errors++;
        end
      end
    end
  end

  // Register writes happen only while the block is idle or still clearing after reset,
  // so the predictor can take the new value at once.
  task automatic write_reg(arbms_pkg::cfg_idx_t idx, int unsigned value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = arbms_pkg::CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      arbms_pkg::CFG_FRAME_WIDTH:  width_reg = value & 11'h7FF;
      arbms_pkg::CFG_FRAME_HEIGHT: height_reg = value & 10'h3FF;
      arbms_pkg::CFG_SEARCH_RANGE: range_reg = value & 3'h7;
      arbms_pkg::CFG_THRESHOLD:    thr_reg = value & 8'hFF;
      default: ;
    endcase
  endtask

  // Waits until every word has been sent and every result has come back, then gives
  // a word that yields no result time to drain out of the block.
  task automatic wait_drained();
    while (pending_words.size() > 0 || in_if.valid || expected_vectors.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic pixel_word_t make_word(arbms_pkg::func_t f, int r, int c, int px);
    pixel_word_t wd;
    wd.func = f;
    wd.row = 9'(r);
    wd.col = 10'(c);
    wd.pixel = 8'(px);
    return wd;
  endfunction

  // A smooth test picture; the search frame is the same picture moved by (dx, dy),
  // so blocks have a true match for the search to find.
  function automatic int scene_px(int r, int c, int ka, int kb);
    return (r * ka + c * kb + ((r * c) >>> 2)) & 255;
  endfunction

  task automatic fill_frames(int dx, int dy, int ka, int kb);
    int w, h;
    w = (width_reg > MW) ? MW : width_reg;
    h = (height_reg > MH) ? MH : height_reg;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        pending_words.push_back(make_word(arbms_pkg::FUNC_LOAD_ANCHOR, r, c,
                                          scene_px(r, c, ka, kb)));
        pending_words.push_back(make_word(arbms_pkg::FUNC_LOAD_SEARCH, r, c,
                                          scene_px(r - dy, c - dx, ka, kb)));
      end
  endtask

  // Random traffic: searches of blocks inside the frame (only when every pixel the
  // frame holds has been loaded), often swept along a block row so the left vector
  // feeds the rood arm, mixed with pixel noise, loads anywhere in the store,
  // searches of blocks that never fit the frame and the unused code.
  task automatic random_words(int count, bit frame_loaded);
    int w, h, k, br, bc, n;
    w = (width_reg > MW) ? MW : width_reg;
    h = (height_reg > MH) ? MH : height_reg;
    for (int q = 0; q < count; q++) begin
      k = $urandom_range(99);
      if (k < 40 && w > 0 && h > 0) begin
        pending_words.push_back(make_word($urandom_range(1) ? arbms_pkg::FUNC_LOAD_ANCHOR :
                                          arbms_pkg::FUNC_LOAD_SEARCH, $urandom_range(h - 1),
                                          $urandom_range(w - 1), $urandom_range(255)));
      end else if (k < 80 && frame_loaded && w >= BS && h >= BS) begin
        br = $urandom_range(h / BS - 1);
        bc = $urandom_range(w / BS - 1);
        n = $urandom_range(3) == 0 ? $urandom_range(4, 1) : 1;
        for (int s = 0; s < n && bc + s < w / BS; s++)
          pending_words.push_back(make_word(arbms_pkg::FUNC_SEARCH, br, bc + s,
                                            $urandom_range(255)));
      end else if (k < 88) begin
        if ($urandom_range(1))
          pending_words.push_back(make_word(arbms_pkg::FUNC_SEARCH, $urandom_range(511),
                                            $urandom_range(1023, w / BS),
                                            $urandom_range(255)));
        else
          pending_words.push_back(make_word(arbms_pkg::FUNC_SEARCH,
                                            $urandom_range(511, h / BS),
                                            $urandom_range(1023), $urandom_range(255)));
      end else if (k < 94) begin
        pending_words.push_back(make_word(arbms_pkg::FUNC_NONE, $urandom_range(511),
                                          $urandom_range(1023), $urandom_range(255)));
      end else begin
        pending_words.push_back(make_word($urandom_range(1) ? arbms_pkg::FUNC_LOAD_ANCHOR :
                                          arbms_pkg::FUNC_LOAD_SEARCH, $urandom_range(511),
                                          $urandom_range(1023), $urandom_range(255)));
      end
    end
  endtask

  task automatic set_regs(int unsigned w, int unsigned h, int unsigned p, int unsigned t);
    write_reg(arbms_pkg::CFG_FRAME_WIDTH, w);
    write_reg(arbms_pkg::CFG_FRAME_HEIGHT, h);
    write_reg(arbms_pkg::CFG_SEARCH_RANGE, p);
    write_reg(arbms_pkg::CFG_THRESHOLD, t);
  endtask

  // One phase: idle the block, set the registers and the handshake pressure, then
  // send random words over the picture already loaded.
  task automatic run_phase(int unsigned w, int unsigned h, int unsigned p, int unsigned t,
                           int idle, int stall, int count, bit frame_loaded);
    wait_drained();
    set_regs(w, h, p, t);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    random_words(count, frame_loaded);
  endtask

  initial begin
    for (int b = 0; b < BLOCK_COUNT; b++) begin
      stored_mvx[b] = 0;
      stored_mvy[b] = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part on a 16x16 frame: a search range of zero, so the square holds only
    // the best point, and a threshold of zero, so nothing stops early. Loads at the far
    // corner of the store and at pixel extremes, the unused code, searches outside the
    // frame and a row sweep that hands a left vector to the next block.
    set_regs(16, 16, 0, 0);
    fill_frames(1, -2, 5, 3);
    pending_words.push_back(make_word(arbms_pkg::FUNC_SEARCH, 0, 0, 0));
    pending_words.push_back(make_word(arbms_pkg::FUNC_SEARCH, 0, 1, 0));
    pending_words.push_back(make_word(arbms_pkg::FUNC_SEARCH, 1, 0, 0));
    pending_words.push_back(make_word(arbms_pkg::FUNC_SEARCH, 1, 1, 0));
    pending_words.push_back(make_word(arbms_pkg::FUNC_LOAD_ANCHOR, 511, 1023, 255));
    pending_words.push_back(make_word(arbms_pkg::FUNC_LOAD_SEARCH, 511, 1023, 0));
    pending_words.push_back(make_word(arbms_pkg::FUNC_NONE, 511, 1023, 255));
    pending_words.push_back(make_word(arbms_pkg::FUNC_SEARCH, 2, 0, 0));
    pending_words.push_back(make_word(arbms_pkg::FUNC_SEARCH, 0, 2, 0));
    pending_words.push_back(make_word(arbms_pkg::FUNC_SEARCH, 511, 1023, 255));
    pending_words.push_back(make_word(arbms_pkg::FUNC_LOAD_ANCHOR, 0, 0, 0));
    pending_words.push_back(make_word(arbms_pkg::FUNC_LOAD_SEARCH, 0, 0, 255));
    pending_words.push_back(make_word(arbms_pkg::FUNC_SEARCH, 0, 0, 0));
    pending_words.push_back(make_word(arbms_pkg::FUNC_SEARCH, 0, 1, 0));

    // Same frame again with the top threshold: zero motion is accepted at once.
    wait_drained();
    write_reg(arbms_pkg::CFG_THRESHOLD, 255);
    pending_words.push_back(make_word(arbms_pkg::FUNC_SEARCH, 1, 0, 0));
    pending_words.push_back(make_word(arbms_pkg::FUNC_SEARCH, 1, 1, 0));

    // Random phases inside the loaded 16x16 picture and across the register
    // extremes. An oversized width or height is clamped to the store, and there
    // only blocks beyond the clamped frame are searched. A zero-sized frame
    // ignores every search.
    run_phase(16, 16, 3, 8, 0, 0, 60, 1'b1);
    run_phase(16, 16, 7, 1, 0, 81, 60, 1'b1);
    run_phase(16, 8, 2, 4, 81, 0, 60, 1'b1);
    run_phase(16, 16, 1, 3, 28, 28, 60, 1'b1);
    run_phase(2047, 1023, 5, 255, 0, 0, 40, 1'b0);
    run_phase(0, 0, 4, 1, 28, 28, 20, 1'b0);
    run_phase(8, 16, 3, 0, 0, 0, 30, 1'b1);

    wait_drained();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #200000000;
    $display("status: fail");
    $finish;
  end

endmodule
